### sv/lmtk_pkg.sv
// Shared types, constants and saturation helpers for the lateral maneuver
// target kinematics block. No dependencies.
package lmtk_pkg;

    localparam int A16W = 35;
    localparam int DIRW = 17;
    localparam logic [19:0] G_Q16 = 20'd642689;

    localparam logic signed [65:0] P48_MAX = 66'sh7FFF_FFFF_FFFF;
    localparam logic signed [65:0] P48_MIN = -P48_MAX - 66'sd1;
    localparam logic signed [44:0] V32_MAX = 45'sh7FFF_FFFF;
    localparam logic signed [44:0] V32_MIN = -V32_MAX - 45'sd1;

    // Lateral acceleration set derived from the configuration registers.
    typedef struct packed {
        logic [1:0][A16W-1:0] a16;
        logic [1:0]           neg;
        logic [1:0][31:0]     acc;
    } t_dir;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [47:0] sat48(input logic signed [65:0] x);
        logic signed [65:0] y;
        y = x;
        if (x > P48_MAX) begin
            y = P48_MAX;
        end else if (x < P48_MIN) begin
            y = P48_MIN;
        end
        return y[47:0];
    endfunction

    function automatic logic [31:0] sat32(input logic signed [44:0] x);
        logic signed [44:0] y;
        y = x;
        if (x > V32_MAX) begin
            y = V32_MAX;
        end else if (x < V32_MIN) begin
            y = V32_MIN;
        end
        return y[31:0];
    endfunction

endpackage

### sv/lmtk_if.sv
// Valid/ready channel interfaces for query requests and kinematic results.
// Depends on nothing beyond plain logic types.
interface lmtk_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] query_time;

    modport source (output valid, output query_time, input ready);
    modport sink (input valid, input query_time, output ready);
endinterface

interface lmtk_res_if;
    logic        valid;
    logic        ready;
    logic [47:0] pos_north;
    logic [47:0] pos_east;
    logic [47:0] pos_down;
    logic [31:0] vel_north;
    logic [31:0] vel_east;
    logic [31:0] vel_down;
    logic [31:0] acc_north;
    logic [31:0] acc_east;
    logic [31:0] acc_down;

    modport source (output valid, output pos_north, output pos_east, output pos_down,
                    output vel_north, output vel_east, output vel_down,
                    output acc_north, output acc_east, output acc_down, input ready);
    modport sink (input valid, input pos_north, input pos_east, input pos_down,
                  input vel_north, input vel_east, input vel_down,
                  input acc_north, input acc_east, input acc_down, output ready);
endinterface

### sv/lmtk_dir.sv
// Sequential unit that turns the horizontal velocity and maneuver load into
// fixed-point lateral acceleration terms. Depends on lmtk_pkg.
module lmtk_dir (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_vel_n,
    input  logic [31:0]        i_vel_e,
    input  logic [15:0]        i_load_g,
    output lmtk_pkg::t_dir     o_dir,
    output logic               o_busy
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_SUM  = 4'd2;
    localparam logic [3:0] ST_NORM = 4'd3;
    localparam logic [3:0] ST_ROOT = 4'd4;
    localparam logic [3:0] ST_DSET = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_GG   = 4'd7;
    localparam logic [3:0] ST_AMUL = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;

    logic [3:0]  r_st;
    logic        r_busy;
    logic [63:0] r_sqn, r_sqe;
    logic [63:0] r_x, r_rt, r_b;
    logic [4:0]  r_k, r_cnt;
    logic        r_sel;
    logic [48:0] r_rem, r_dsh;
    logic [16:0] r_qt;
    logic [1:0][lmtk_pkg::DIRW-1:0] r_dmag;
    logic [34:0] r_gg;
    logic [1:0][lmtk_pkg::A16W-1:0] r_a16;
    logic [1:0][31:0] r_acc;
    logic [1:0]  r_neg;

    logic [31:0] w_mn, w_me, w_csel, w_sh32;
    logic [15:0] w_gmag;
    logic [35:0] w_gg_full;
    logic [63:0] w_sum, w_shk;
    logic [64:0] w_root_t;
    logic        w_root_ge, w_div_ge;
    logic [48:0] w_dnum, w_dden;
    logic [16:0] n_qt;
    logic [1:0][lmtk_pkg::A16W-1:0] n_a16;
    logic [1:0][31:0] n_acc;
    logic [1:0]  n_neg;

    always_comb begin
        logic [51:0] prod;
        logic [35:0] rnd;
        w_mn      = lmtk_pkg::mag32(i_vel_n);
        w_me      = lmtk_pkg::mag32(i_vel_e);
        w_gmag    = i_load_g[15] ? (~i_load_g + 16'd1) : i_load_g;
        w_gg_full = 36'(w_gmag) * 36'(lmtk_pkg::G_Q16);
        w_sum     = r_sqn + r_sqe;
        w_root_t  = {1'b0, r_rt} + {1'b0, r_b};
        w_root_ge = {1'b0, r_x} >= w_root_t;
        w_csel    = r_sel ? w_mn : w_me;
        w_shk     = 64'(w_csel) << r_k;
        // The shifted component never exceeds the root, so 32 bits hold it.
        w_sh32    = w_shk[31:0];
        w_dnum    = {1'b0, w_sh32, 16'b0} + 49'(r_rt[31:0]);
        w_dden    = {r_rt[31:0], 17'b0};
        w_div_ge  = r_rem >= r_dsh;
        n_qt      = {r_qt[15:0], w_div_ge};
        n_neg[0]  = i_load_g[15] ^ (~i_vel_e[31] & (|i_vel_e));
        n_neg[1]  = i_load_g[15] ^ i_vel_n[31];
        for (int j = 0; j < 2; j++) begin
            prod     = 52'(r_gg) * 52'(r_dmag[j]);
            prod     = prod + 52'd16384;
            n_a16[j] = prod[49:15];
            rnd      = 36'(r_a16[j]) + 36'd32768;
            n_acc[j] = n_neg[j] ? (32'd0 - 32'(rnd[35:16])) : 32'(rnd[35:16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_busy <= 1'b0;
            r_a16  <= '0;
            r_acc  <= '0;
            r_neg  <= '0;
        end else if (i_start) begin
            r_st   <= ST_SQ;
            r_busy <= 1'b1;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    r_st <= ST_IDLE;
                end
                ST_SQ: begin
                    r_sqn <= 64'(w_mn) * 64'(w_mn);
                    r_sqe <= 64'(w_me) * 64'(w_me);
                    r_st  <= ST_SUM;
                end
                ST_SUM: begin
                    r_sel <= 1'b0;
                    if (w_sum == 64'd0) begin
                        // No horizontal motion: the turn points due east.
                        r_dmag[0] <= '0;
                        r_dmag[1] <= 17'd32768;
                        r_st      <= ST_GG;
                    end else begin
                        r_x  <= w_sum;
                        r_k  <= '0;
                        r_st <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    if (r_x[63:60] == 4'd0) begin
                        r_x <= {r_x[61:0], 2'b00};
                        r_k <= r_k + 5'd1;
                    end else begin
                        r_rt  <= '0;
                        r_b   <= 64'h4000_0000_0000_0000;
                        r_cnt <= 5'd31;
                        r_st  <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (w_root_ge) begin
                        r_x  <= r_x - w_root_t[63:0];
                        r_rt <= (r_rt >> 1) + r_b;
                    end else begin
                        r_rt <= r_rt >> 1;
                    end
                    r_b   <= r_b >> 2;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_st <= ST_DSET;
                    end
                end
                ST_DSET: begin
                    r_rem <= w_dnum;
                    r_dsh <= w_dden;
                    r_qt  <= '0;
                    r_cnt <= 5'd16;
                    r_st  <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_qt  <= n_qt;
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        if (!r_sel) begin
                            r_dmag[0] <= n_qt;
                            r_sel     <= 1'b1;
                            r_st      <= ST_DSET;
                        end else begin
                            r_dmag[1] <= n_qt;
                            r_st      <= ST_GG;
                        end
                    end
                end
                ST_GG: begin
                    r_gg <= w_gg_full[34:0];
                    r_st <= ST_AMUL;
                end
                ST_AMUL: begin
                    r_a16 <= n_a16;
                    r_st  <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc  <= n_acc;
                    r_neg  <= n_neg;
                    r_busy <= 1'b0;
                    r_st   <= ST_IDLE;
                end
                default: begin
                    r_st   <= ST_IDLE;
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

    assign o_dir.a16 = r_a16;
    assign o_dir.neg = r_neg;
    assign o_dir.acc = r_acc;
    assign o_busy    = r_busy;

endmodule

### sv/lateral_maneuver_target_kinematics_top.sv
// Top level of the lateral maneuver target kinematics block: APB registers,
// the six-stage query pipeline and the lateral term unit. Uses lmtk_pkg,
// lmtk_req_if, lmtk_res_if and lmtk_dir.
//
// The block answers one time query per clock cycle while the output is ready
// and the lateral term unit is idle; each request passes six register stages,
// r0 to r5, and its result is held in the last one, the output register. A
// stalled output only holds the stages behind it that are full. Any register
// write restarts a sequential unit (squares, normalization, a 32-step square
// root and two 17-step divisions) that rebuilds the lateral acceleration terms;
// while it runs, the request channel is not ready. Registers lie at byte
// address 8*i with 64-bit data.
module lateral_maneuver_target_kinematics_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmtk_req_if.sink    i_req,
    lmtk_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_POS_N = 3'd0;
    localparam logic [2:0] REG_POS_E = 3'd1;
    localparam logic [2:0] REG_POS_D = 3'd2;
    localparam logic [2:0] REG_VEL_N = 3'd3;
    localparam logic [2:0] REG_VEL_E = 3'd4;
    localparam logic [2:0] REG_VEL_D = 3'd5;
    localparam logic [2:0] REG_LOAD  = 3'd6;
    localparam logic [2:0] REG_TBEG  = 3'd7;
    localparam int NST = 6;

    logic [2:0][47:0] r_pos0;
    logic [2:0][31:0] r_vel0;
    logic [15:0]      r_gload;
    logic [31:0]      r_tbeg;

    logic             w_cfg_wr, w_busy, w_in_acc;
    lmtk_pkg::t_dir   w_dir;
    logic [NST:0]     w_en;
    logic [NST-1:0]   r_vld;

    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos0  <= '0;
            r_vel0  <= '0;
            r_gload <= '0;
            r_tbeg  <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[5:3])
                REG_POS_N: r_pos0[0] <= pwdata[47:0];
                REG_POS_E: r_pos0[1] <= pwdata[47:0];
                REG_POS_D: r_pos0[2] <= pwdata[47:0];
                REG_VEL_N: r_vel0[0] <= pwdata[31:0];
                REG_VEL_E: r_vel0[1] <= pwdata[31:0];
                REG_VEL_D: r_vel0[2] <= pwdata[31:0];
                REG_LOAD:  r_gload   <= pwdata[15:0];
                REG_TBEG:  r_tbeg    <= pwdata[31:0];
                default:   r_tbeg    <= r_tbeg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_POS_N: prdata = {16'b0, r_pos0[0]};
            REG_POS_E: prdata = {16'b0, r_pos0[1]};
            REG_POS_D: prdata = {16'b0, r_pos0[2]};
            REG_VEL_N: prdata = {32'b0, r_vel0[0]};
            REG_VEL_E: prdata = {32'b0, r_vel0[1]};
            REG_VEL_D: prdata = {32'b0, r_vel0[2]};
            REG_LOAD:  prdata = {48'b0, r_gload};
            REG_TBEG:  prdata = {32'b0, r_tbeg};
            default:   prdata = '0;
        endcase
    end

    lmtk_dir u_dir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_cfg_wr),
        .i_vel_n  (r_vel0[0]),
        .i_vel_e  (r_vel0[1]),
        .i_load_g (r_gload),
        .o_dir    (w_dir),
        .o_busy   (w_busy)
    );

    // A stage may load when it is empty or when the stage after it moves.
    always_comb begin
        w_en[NST] = o_res.ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = ~r_vld[k] | w_en[k+1];
        end
    end

    assign i_req.ready = w_en[0] & ~w_busy & ~w_cfg_wr;
    assign w_in_acc    = i_req.valid & i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= w_in_acc;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage registers.
    logic [31:0]            r0_t;
    logic [31:0]            r1_dt, r2_dt;
    logic                   r1_aft, r2_aft, r3_aft, r4_aft;
    logic [1:0][48:0]       r1_pl;
    logic [1:0][49:0]       r1_ph;
    logic [2:0][63:0]       r1_m;
    logic [1:0][41:0]       r2_dv;
    logic [1:0][57:0]       r2_q;
    logic [2:0][55:0]       r2_base, r3_base, r4_base;
    logic [2:0][31:0]       r3_vel, r4_vel, r5_vel;
    logic [1:0][60:0]       r3_q0dt, r3_q1dt;
    logic [1:0][63:0]       r4_dp;
    logic [2:0][47:0]       r5_pos;
    logic [1:0][31:0]       r5_acc;

    logic [31:0]            n1_dt;
    logic                   n1_aft;
    logic [1:0][48:0]       n1_pl;
    logic [1:0][49:0]       n1_ph;
    logic [2:0][63:0]       n1_m;
    logic [1:0][41:0]       n2_dv;
    logic [1:0][57:0]       n2_q;
    logic [2:0][55:0]       n2_base;
    logic [2:0][31:0]       n3_vel;
    logic [1:0][60:0]       n3_q0dt, n3_q1dt;
    logic [1:0][63:0]       n4_dp;
    logic [2:0][47:0]       n5_pos;
    logic [1:0][31:0]       n5_acc;

    always_comb begin
        logic [34:0]        aop;
        logic [66:0]        p;
        logic [67:0]        pr26, pr10;
        logic [63:0]        bm;
        logic signed [55:0] bs, p0x;
        logic signed [44:0] vx, dvs;
        logic [89:0]        qq;
        logic [90:0]        qr;
        logic signed [65:0] px, dps;

        n1_dt  = r0_t - r_tbeg;
        n1_aft = r0_t >= r_tbeg;
        for (int j = 0; j < 2; j++) begin
            aop      = n1_aft ? w_dir.a16[j] : '0;
            n1_pl[j] = 49'(aop[16:0]) * 49'(n1_dt);
            n1_ph[j] = 50'(aop[34:17]) * 50'(n1_dt);
        end
        for (int i = 0; i < 3; i++) begin
            n1_m[i] = 64'(lmtk_pkg::mag32(r_vel0[i])) * 64'(r0_t);
        end

        for (int j = 0; j < 2; j++) begin
            p        = {r1_ph[j], 17'b0} + 67'(r1_pl[j]);
            pr26     = 68'(p) + 68'd33554432;
            pr10     = 68'(p) + 68'd512;
            n2_dv[j] = pr26[67:26];
            n2_q[j]  = pr10[67:10];
        end
        for (int i = 0; i < 3; i++) begin
            bm         = r1_m[i] + 64'd512;
            bs         = $signed({2'b00, bm[63:10]});
            p0x        = $signed({{8{r_pos0[i][47]}}, r_pos0[i]});
            n2_base[i] = p0x + (r_vel0[i][31] ? -bs : bs);
        end

        for (int j = 0; j < 2; j++) begin
            n3_q0dt[j] = 61'(r2_q[j][28:0]) * 61'(r2_dt);
            n3_q1dt[j] = 61'(r2_q[j][57:29]) * 61'(r2_dt);
            dvs        = $signed({3'b000, r2_dv[j]});
            vx         = $signed({{13{r_vel0[j][31]}}, r_vel0[j]});
            vx         = vx + (w_dir.neg[j] ? -dvs : dvs);
            n3_vel[j]  = lmtk_pkg::sat32(vx);
        end
        n3_vel[2] = r_vel0[2];

        for (int j = 0; j < 2; j++) begin
            qq       = {r3_q1dt[j], 29'b0} + 90'(r3_q0dt[j]);
            qr       = 91'(qq) + 91'd67108864;
            n4_dp[j] = qr[90:27];
        end

        for (int j = 0; j < 2; j++) begin
            dps       = $signed({2'b00, r4_dp[j]});
            px        = $signed({{10{r4_base[j][55]}}, r4_base[j]});
            px        = px + (w_dir.neg[j] ? -dps : dps);
            n5_pos[j] = lmtk_pkg::sat48(px);
            n5_acc[j] = r4_aft ? w_dir.acc[j] : 32'd0;
        end
        n5_pos[2] = lmtk_pkg::sat48($signed({{10{r4_base[2][55]}}, r4_base[2]}));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_t <= i_req.query_time;
        end
        if (w_en[1]) begin
            r1_dt  <= n1_dt;
            r1_aft <= n1_aft;
            r1_pl  <= n1_pl;
            r1_ph  <= n1_ph;
            r1_m   <= n1_m;
        end
        if (w_en[2]) begin
            r2_dt   <= r1_dt;
            r2_aft  <= r1_aft;
            r2_dv   <= n2_dv;
            r2_q    <= n2_q;
            r2_base <= n2_base;
        end
        if (w_en[3]) begin
            r3_aft  <= r2_aft;
            r3_vel  <= n3_vel;
            r3_q0dt <= n3_q0dt;
            r3_q1dt <= n3_q1dt;
            r3_base <= r2_base;
        end
        if (w_en[4]) begin
            r4_aft  <= r3_aft;
            r4_vel  <= r3_vel;
            r4_dp   <= n4_dp;
            r4_base <= r3_base;
        end
        if (w_en[5]) begin
            r5_vel <= r4_vel;
            r5_pos <= n5_pos;
            r5_acc <= n5_acc;
        end
    end

    assign o_res.valid     = r_vld[NST-1];
    assign o_res.pos_north = r5_pos[0];
    assign o_res.pos_east  = r5_pos[1];
    assign o_res.pos_down  = r5_pos[2];
    assign o_res.vel_north = r5_vel[0];
    assign o_res.vel_east  = r5_vel[1];
    assign o_res.vel_down  = r5_vel[2];
    assign o_res.acc_north = r5_acc[0];
    assign o_res.acc_east  = r5_acc[1];
    assign o_res.acc_down  = 32'd0;

    a_req_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !i_req.ready)
        else $error("request channel ready while lateral terms are rebuilt");

    a_write_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> w_busy)
        else $error("register write did not start the lateral term unit");

endmodule
